/* design/htw_pkg.sv */
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by the core, the sequencer and the checker.
`timescale 1ns / 1ps

package htw_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int NODE_DEPTH_DEF   = 512;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // register index (word select of paddr)
  localparam logic REG_ROOT = 1'b0;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic             start;
    logic             code_bit;
    logic             cfg_load;
    logic [IDX_W-1:0] cfg_root;
  } htw_cmd_t;

endpackage

/* design/huffman_tree_walk_decoder_core.sv */
// Huffman tree-walk decoder: a write item never stalls and the next may follow at once.
// A decode holds stall for a current-node read, then a child read or fault load, and
// a result load when the child is a leaf; an inner child only advances the walk.
// Results take longer while the output stalls. The one table read port sets this.
// Synchronous reset clears the root register and the walk to 0; the node table is
// not cleared and must be written before it is walked.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_core #(
  parameter int SYMBOL_COUNT = htw_pkg::SYMBOL_COUNT_DEF,
  parameter int NODE_DEPTH   = htw_pkg::NODE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [htw_pkg::IDX_W-1:0]    node_index,
  input  logic                         node_is_leaf,
  input  logic [htw_pkg::SYM_W-1:0]    node_symbol,
  input  logic [htw_pkg::IDX_W-1:0]    left_child,
  input  logic [htw_pkg::IDX_W-1:0]    right_child,
  input  logic                         code_bit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [htw_pkg::SYM_W-1:0]    symbol,
  output logic                         fault,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htw_pkg::ADDR_W-1:0]   paddr,
  input  logic [htw_pkg::DATA_W-1:0]   pwdata,
  output logic [htw_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import htw_pkg::*;

  localparam int AW = $clog2(NODE_DEPTH);

  logic [IDX_W-1:0]  root_index;
  logic              accept;
  logic              busy;
  logic              cfg_wr;
  logic              idx_ok;
  logic              we;
  logic [SYM_W-1:0]  sym_sat;
  node_t             wdata;
  node_t             rdata;
  logic [AW-1:0]     raddr;
  htw_cmd_t          cmd;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // APB register file: root index only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ROOT);
  assign prdata = (paddr[2] == REG_ROOT) ? DATA_W'(root_index) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_index <= '0;
    end else if (cfg_wr) begin
      root_index <= pwdata[IDX_W-1:0];
    end
  end

  // clamp symbols beyond the alphabet; drop writes beyond the table
  assign sym_sat = ({1'b0, node_symbol} >= (SYM_W + 1)'(SYMBOL_COUNT))
                   ? SYM_W'(SYMBOL_COUNT - 1) : node_symbol;
  assign idx_ok  = {1'b0, node_index} < (IDX_W + 1)'(NODE_DEPTH);
  assign we      = accept && (action == ACT_WRITE) && idx_ok;

  always_comb begin
    wdata.leaf  = node_is_leaf;
    wdata.sym   = sym_sat;
    wdata.left  = left_child;
    wdata.right = right_child;
  end

  always_comb begin
    cmd.start    = accept && (action == ACT_DECODE);
    cmd.code_bit = code_bit;
    cmd.cfg_load = cfg_wr;
    cmd.cfg_root = pwdata[IDX_W-1:0];
  end

  htw_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (node_index[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  htw_seq #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .root      (root_index),
    .raddr     (raddr),
    .rdata     (rdata),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .fault     (fault)
  );

endmodule

/* design/htw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/htw_seq.sv */
// Walk sequencer: reads the current node, selects the child, reads it and
// decides on a result, all through the one read port of the node table.
// Depends on htw_pkg.
`timescale 1ns / 1ps

module htw_seq #(
  parameter int NODE_DEPTH = htw_pkg::NODE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  htw_pkg::htw_cmd_t               cmd,
  input  logic [htw_pkg::IDX_W-1:0]       root,
  output logic [$clog2(NODE_DEPTH)-1:0]   raddr,
  input  htw_pkg::node_t                  rdata,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [htw_pkg::SYM_W-1:0]       symbol,
  output logic                            fault
);
  import htw_pkg::*;

  localparam int AW = $clog2(NODE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CUR  = 2'd1;
  localparam logic [1:0] S_NXT  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] walk;
  logic             bit_r;
  logic [IDX_W-1:0] next_pos;
  logic             rd_oor;
  logic [SYM_W-1:0] res_symbol;
  logic             res_fault;

  logic [IDX_W-1:0] rd_idx;
  logic             oor_now;
  node_t            entry;
  logic [IDX_W-1:0] child;
  logic             out_free;

  // one read address: the child while checking the current node, else the walk
  assign rd_idx  = (state == S_CUR) ? child : walk;
  assign raddr   = rd_idx[AW-1:0];
  assign oor_now = {1'b0, rd_idx} >= (IDX_W + 1)'(NODE_DEPTH);

  // entries beyond the table read as an empty inner node
  assign entry    = rd_oor ? '0 : rdata;
  assign child    = bit_r ? entry.right : entry.left;
  assign out_free = !out_valid || !out_stall;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.start) state_next = S_CUR;
      S_CUR:  state_next = entry.leaf ? S_OUT : S_NXT;
      S_NXT:  state_next = entry.leaf ? S_OUT : S_IDLE;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cfg_load) begin
        walk <= cmd.cfg_root;
      end else if ((state == S_CUR && entry.leaf) || (state == S_NXT && entry.leaf)) begin
        walk <= root;
      end else if (state == S_NXT) begin
        walk <= next_pos;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_oor <= oor_now;
    if (state == S_IDLE && cmd.start) begin
      bit_r <= cmd.code_bit;
    end
    if (state == S_CUR) begin
      next_pos   <= child;
      res_symbol <= '0;
      res_fault  <= 1'b1;
    end
    if (state == S_NXT) begin
      res_symbol <= entry.sym;
      res_fault  <= 1'b0;
    end
    if (state == S_OUT && out_free) begin
      symbol <= res_symbol;
      fault  <= res_fault;
    end
  end

endmodule

/* design/htw_checker.sv */
// Port-level checks for the Huffman tree-walk decoder, bound to the top level.
// Depends on htw_pkg.
`timescale 1ns / 1ps

module htw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       action,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [htw_pkg::SYM_W-1:0]  symbol,
  input logic                       fault,
  input logic                       pready
);
  import htw_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(fault))
    else $error("stalled result changed");

  // a fault result carries symbol zero
  a_fault_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> symbol == '0)
    else $error("fault result with nonzero symbol");

  // a decode transfer occupies the walker
  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall && action == ACT_DECODE |=> in_stall ##1 in_stall)
    else $error("decode transfer did not hold stall");

  // a node write finishes in its own cycle
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall && action == ACT_WRITE |=> !in_stall)
    else $error("node write stalled the input");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind huffman_tree_walk_decoder_core htw_checker u_htw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .fault     (fault),
  .pready    (pready)
);
